@@ src/lrkm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrkm_pkg
// Types and codes shared by the learned remote key mapper modules.
// ----------------------------------------------------------------------------
package lrkm_pkg;

  localparam logic [2:0] OP_FRAME  = 3'd0;
  localparam logic [2:0] OP_TEST   = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_CANCEL = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_STORED  = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam logic [1:0] CFG_HELD_GAP    = 2'd0;
  localparam logic [1:0] CFG_RELEASE_GAP = 2'd1;
  localparam logic [1:0] CFG_REPEAT_MASK = 2'd2;
  localparam logic [1:0] CFG_UNKNOWN     = 2'd3;

  localparam logic [3:0] NO_ACTION  = 4'd8;
  localparam int         MAX_LOOKUP = 8;

  typedef enum logic [2:0] {
    K_FRAME,
    K_TEST,
    K_START,
    K_CANCEL,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [15:0] address;
    logic [15:0] command;
    logic [15:0] extra;
    logic [15:0] bit_count;
    logic [63:0] raw_word;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    logic        is_repeat;
    logic        is_bad;
    logic [31:0] now_ms;
    entry_t      entry;
  } item_t;

  typedef struct packed {
    logic [15:0] held_gap_ms;
    logic [15:0] release_gap_ms;
    logic [7:0]  repeat_mask;
    logic [7:0]  unknown_protocol_code;
  } cfg_t;

  typedef struct packed {
    logic [3:0] action;
    logic       fire;
    logic [2:0] learn_status;
    logic [3:0] learn_progress;
    logic       profile_valid;
    logic       learning;
  } result_t;

endpackage

@@ src/lrkm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrkm_front
// Takes command transactions and classifies them for the execution side.
// ----------------------------------------------------------------------------
module lrkm_front import lrkm_pkg::*; (
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_address,
  input  logic [15:0] in_command,
  input  logic [15:0] in_extra,
  input  logic [15:0] in_bit_count,
  input  logic [63:0] in_raw_word,
  input  logic        in_is_repeat,
  input  logic        in_is_bad,
  input  logic [31:0] in_now_ms,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  kind_t kind;

  always_comb begin
    unique case (in_opcode)
      OP_FRAME:  kind = K_FRAME;
      OP_TEST:   kind = in_is_bad ? K_NOP : K_TEST;
      OP_START:  kind = K_START;
      OP_CANCEL: kind = K_CANCEL;
      OP_CLEAR:  kind = K_CLEAR;
      default:   kind = K_NOP;
    endcase
  end

  assign busy   = q_full;
  assign q_push = start && !q_full;

  assign q_item = '{
    kind:      kind,
    is_repeat: in_is_repeat,
    is_bad:    in_is_bad,
    now_ms:    in_now_ms,
    entry:     '{protocol:  in_protocol,
                 address:   in_address,
                 command:   in_command,
                 extra:     in_extra,
                 bit_count: in_bit_count,
                 raw_word:  in_raw_word}
  };

endmodule

@@ src/lrkm_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrkm_fifo
// Two-entry queue between the classifying front and the execution back.
// ----------------------------------------------------------------------------
module lrkm_fifo import lrkm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t rd_item,
  output logic  full,
  output logic  empty
);

  item_t      items_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign rd_item = items_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      items_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ src/lrkm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrkm_back
// Executes queued transactions: table scans, learning and run-mode mapping.
// ----------------------------------------------------------------------------
module lrkm_back import lrkm_pkg::*; #(
  parameter int KEYS = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    res_valid,
  output result_t res
);

  localparam int         IW       = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int         DEPTH    = 2 ** (IW + 1);
  localparam logic [3:0] KEYS_C   = 4'(KEYS);
  localparam logic [3:0] LOOK_LEN = 4'((KEYS < MAX_LOOKUP) ? KEYS : MAX_LOOKUP);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  item_t       cur_r, cur_nxt;
  logic        valid_r, valid_nxt;
  logic        learn_mode_r, learn_mode_nxt;
  logic [3:0]  learn_count_r, learn_count_nxt;
  logic        wait_rel_r, wait_rel_nxt;
  logic [31:0] learn_last_r, learn_last_nxt;
  logic [3:0]  last_act_r, last_act_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic        bank_r, bank_nxt;
  logic        wait_eff_r, wait_eff_nxt;
  logic        held_win_r, held_win_nxt;
  logic [3:0]  scan_len_r, scan_len_nxt;
  logic        scan_bank_r, scan_bank_nxt;
  logic [3:0]  rd_idx_r, rd_idx_nxt;
  logic        cmp_v_r, cmp_v_nxt;
  logic [3:0]  cmp_idx_r, cmp_idx_nxt;
  logic        hit_r, hit_nxt;
  logic [3:0]  hit_idx_r, hit_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r, out_nxt;

  entry_t      mem [DEPTH];
  entry_t      rd_data_r;
  logic        rd_en;
  logic        wr_en;
  logic [IW:0] rd_addr;
  logic [IW:0] wr_addr;

  logic        release_ok;
  logic        held_ok;
  logic        entry_hit;
  logic [3:0]  fin_act;
  logic        fin_held;
  logic        fin_fire;
  logic [2:0]  fin_status;

  assign rd_addr = {scan_bank_r, rd_idx_r[IW-1:0]};
  assign wr_addr = {~bank_r, learn_count_r[IW-1:0]};

  assign release_ok = (cur_r.now_ms - learn_last_r) >= {16'd0, cfg.release_gap_ms};
  assign held_ok    = (cur_r.now_ms - last_time_r) < {16'd0, cfg.held_gap_ms};

  always_comb begin
    entry_hit = 1'b0;
    if (rd_data_r.protocol == cur_r.entry.protocol) begin
      if (cur_r.entry.protocol == cfg.unknown_protocol_code) begin
        entry_hit = rd_data_r.raw_word == cur_r.entry.raw_word;
      end else begin
        entry_hit = (rd_data_r.address   == cur_r.entry.address) &&
                    (rd_data_r.command   == cur_r.entry.command) &&
                    (rd_data_r.extra     == cur_r.entry.extra) &&
                    (rd_data_r.bit_count == cur_r.entry.bit_count);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    valid_nxt       = valid_r;
    learn_mode_nxt  = learn_mode_r;
    learn_count_nxt = learn_count_r;
    wait_rel_nxt    = wait_rel_r;
    learn_last_nxt  = learn_last_r;
    last_act_nxt    = last_act_r;
    last_time_nxt   = last_time_r;
    bank_nxt        = bank_r;
    wait_eff_nxt    = wait_eff_r;
    held_win_nxt    = held_win_r;
    scan_len_nxt    = scan_len_r;
    scan_bank_nxt   = scan_bank_r;
    rd_idx_nxt      = rd_idx_r;
    cmp_v_nxt       = cmp_v_r;
    cmp_idx_nxt     = cmp_idx_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    out_valid_nxt   = 1'b0;
    out_nxt         = out_r;
    q_pop           = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    fin_act         = NO_ACTION;
    fin_held        = 1'b0;
    fin_fire        = 1'b0;
    fin_status      = ST_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        wait_eff_nxt  = wait_rel_r && !release_ok;
        held_win_nxt  = held_ok;
        hit_nxt       = 1'b0;
        cmp_v_nxt     = 1'b0;
        rd_idx_nxt    = 4'd0;
        scan_len_nxt  = 4'd0;
        scan_bank_nxt = bank_r;
        case (cur_r.kind)
          K_FRAME: begin
            if (learn_mode_r) begin
              if (!cur_r.is_bad && !cur_r.is_repeat && !wait_eff_nxt) begin
                scan_len_nxt  = learn_count_r;
                scan_bank_nxt = ~bank_r;
              end
            end else if (!cur_r.is_bad && !cur_r.is_repeat && valid_r) begin
              scan_len_nxt = LOOK_LEN;
            end
          end
          K_TEST: begin
            if (valid_r) begin
              scan_len_nxt = LOOK_LEN;
            end
          end
          default: ;
        endcase
        state_nxt = (scan_len_nxt == 4'd0) ? S_FIN : S_SCAN;
      end

      S_SCAN: begin
        rd_en       = rd_idx_r < scan_len_r;
        cmp_v_nxt   = rd_en;
        cmp_idx_nxt = rd_idx_r;
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + 4'd1;
        end
        if (cmp_v_r && (entry_hit || cmp_idx_r == scan_len_r - 4'd1)) begin
          hit_nxt     = entry_hit;
          hit_idx_nxt = cmp_idx_r;
          cmp_v_nxt   = 1'b0;
          state_nxt   = S_FIN;
        end
      end

      S_FIN: begin
        case (cur_r.kind)
          K_FRAME: begin
            if (learn_mode_r) begin
              wait_rel_nxt = wait_eff_r;
              if (!cur_r.is_bad) begin
                learn_last_nxt = cur_r.now_ms;
                if (wait_eff_r || cur_r.is_repeat) begin
                  fin_status = ST_IGNORED;
                end else if (hit_r) begin
                  wait_rel_nxt = 1'b1;
                  fin_status   = ST_DUP;
                end else if (learn_count_r < KEYS_C) begin
                  wr_en = 1'b1;
                  if (learn_count_r == KEYS_C - 4'd1) begin
                    bank_nxt        = ~bank_r;
                    valid_nxt       = 1'b1;
                    learn_mode_nxt  = 1'b0;
                    learn_count_nxt = 4'd0;
                    wait_rel_nxt    = 1'b0;
                    learn_last_nxt  = 32'd0;
                    fin_status      = ST_DONE;
                  end else begin
                    learn_count_nxt = learn_count_r + 4'd1;
                    wait_rel_nxt    = 1'b1;
                    fin_status      = ST_STORED;
                  end
                end
              end
            end else if (!cur_r.is_bad) begin
              if (cur_r.is_repeat) begin
                fin_act  = last_act_r;
                fin_held = fin_act != NO_ACTION;
              end else begin
                fin_act  = hit_r ? hit_idx_r : NO_ACTION;
                fin_held = (fin_act != NO_ACTION) && (fin_act == last_act_r) && held_win_r;
              end
              last_act_nxt  = fin_act;
              last_time_nxt = cur_r.now_ms;
              if (fin_act != NO_ACTION) begin
                fin_fire = !fin_held ||
                           ((fin_act < NO_ACTION) && cfg.repeat_mask[fin_act[2:0]]);
              end
            end
          end
          K_TEST: begin
            fin_act = hit_r ? hit_idx_r : NO_ACTION;
          end
          K_START: begin
            learn_mode_nxt  = 1'b1;
            learn_count_nxt = 4'd0;
            wait_rel_nxt    = 1'b0;
            learn_last_nxt  = 32'd0;
          end
          K_CANCEL: begin
            learn_mode_nxt  = 1'b0;
            learn_count_nxt = 4'd0;
            wait_rel_nxt    = 1'b0;
            learn_last_nxt  = 32'd0;
          end
          K_CLEAR: begin
            if (valid_r) begin
              valid_nxt     = 1'b0;
              last_act_nxt  = NO_ACTION;
              last_time_nxt = 32'd0;
            end
          end
          default: ;
        endcase
        out_valid_nxt = 1'b1;
        out_nxt = '{
          action:         fin_act,
          fire:           fin_fire,
          learn_status:   fin_status,
          learn_progress: (fin_status == ST_DONE) ? KEYS_C : learn_count_nxt,
          profile_valid:  valid_nxt,
          learning:       learn_mode_nxt
        };
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      valid_r       <= 1'b0;
      learn_mode_r  <= 1'b0;
      learn_count_r <= 4'd0;
      wait_rel_r    <= 1'b0;
      learn_last_r  <= 32'd0;
      last_act_r    <= NO_ACTION;
      last_time_r   <= 32'd0;
      bank_r        <= 1'b0;
      cmp_v_r       <= 1'b0;
      rd_idx_r      <= 4'd0;
      scan_len_r    <= 4'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      valid_r       <= valid_nxt;
      learn_mode_r  <= learn_mode_nxt;
      learn_count_r <= learn_count_nxt;
      wait_rel_r    <= wait_rel_nxt;
      learn_last_r  <= learn_last_nxt;
      last_act_r    <= last_act_nxt;
      last_time_r   <= last_time_nxt;
      bank_r        <= bank_nxt;
      cmp_v_r       <= cmp_v_nxt;
      rd_idx_r      <= rd_idx_nxt;
      scan_len_r    <= scan_len_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    wait_eff_r  <= wait_eff_nxt;
    held_win_r  <= held_win_nxt;
    scan_bank_r <= scan_bank_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cur_r.entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_FIN))
    else $error("result strobe without a finishing step");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    learn_mode_r |-> (learn_count_r < KEYS_C))
    else $error("learn count reached table size while learning");

  a_idle_learn_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !learn_mode_r |-> (learn_count_r == 4'd0 && !wait_rel_r))
    else $error("learn state left over outside learn mode");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cmp_v_r) |-> (cmp_idx_r < scan_len_r))
    else $error("compare beyond scan length");

  a_pop_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_PREP))
    else $error("dequeued transaction not prepared");

endmodule

@@ src/learned_remote_key_mapper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learned_remote_key_mapper
// Maps decoded remote-control frames to learned actions, with a learn mode
// that records a profile of KEYS keys.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; a two-entry
// queue lets start be taken while an earlier transaction is still being
// executed. Each transaction yields exactly one result, shown for a single
// cycle with out_valid high; the receiver cannot stall it. Where a table scan
// is needed, it covers up to min(KEYS,8) entries (the keys stored so far while
// learning), and the scan reads one table entry per cycle
// through the single read port of the key table memory, which holds both the
// active profile and the work table and swaps them on completion. Configuration
// writes are always ready and are to be made while no transaction is pending.
// ----------------------------------------------------------------------------
module learned_remote_key_mapper import lrkm_pkg::*; #(
  parameter int KEYS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_address,
  input  logic [15:0] in_command,
  input  logic [15:0] in_extra,
  input  logic [15:0] in_bit_count,
  input  logic [63:0] in_raw_word,
  input  logic        in_is_repeat,
  input  logic        in_is_bad,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic [3:0]  out_action,
  output logic        out_fire,
  output logic [2:0]  out_learn_status,
  output logic [3:0]  out_learn_progress,
  output logic        out_profile_valid,
  output logic        out_learning,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  logic    q_full;
  logic    q_empty;
  logic    q_push;
  logic    q_pop;
  item_t   q_wr_item;
  item_t   q_rd_item;
  result_t res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HELD_GAP:    cfg_nxt.held_gap_ms           = cfg_data;
        CFG_RELEASE_GAP: cfg_nxt.release_gap_ms        = cfg_data;
        CFG_REPEAT_MASK: cfg_nxt.repeat_mask           = cfg_data[7:0];
        CFG_UNKNOWN:     cfg_nxt.unknown_protocol_code = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{held_gap_ms: 16'd220, release_gap_ms: 16'd220,
                 repeat_mask: 8'd27, unknown_protocol_code: 8'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lrkm_front u_front (
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_protocol  (in_protocol),
    .in_address   (in_address),
    .in_command   (in_command),
    .in_extra     (in_extra),
    .in_bit_count (in_bit_count),
    .in_raw_word  (in_raw_word),
    .in_is_repeat (in_is_repeat),
    .in_is_bad    (in_is_bad),
    .in_now_ms    (in_now_ms),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_wr_item)
  );

  lrkm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  lrkm_back #(
    .KEYS (KEYS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_action         = res.action;
  assign out_fire           = res.fire;
  assign out_learn_status   = res.learn_status;
  assign out_learn_progress = res.learn_progress;
  assign out_profile_valid  = res.profile_valid;
  assign out_learning       = res.learning;

endmodule
